// File: design/btb_pkg.sv
// Shared types and constants of the branch target buffer.
package btb_pkg;

    // Fixed field widths.
    localparam int PC_W  = 32;
    localparam int TAG_W = 30;
    localparam int CNT_W = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LOG2_ENTRIES  = 3'd0;
    localparam logic [2:0] CFG_HISTORY_BITS  = 3'd1;
    localparam logic [2:0] CFG_TAG_BITS      = 3'd2;
    localparam logic [2:0] CFG_INIT_COUNTER  = 3'd3;
    localparam logic [2:0] CFG_GLOBAL_HIST   = 3'd4;
    localparam logic [2:0] CFG_GLOBAL_TABLE  = 3'd5;
    localparam logic [2:0] CFG_SHARE_MODE    = 3'd6;

    // Operation codes.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Share modes.
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    // Bit where the high share mode takes word-address bits.
    localparam int SHARE_HIGH_LSB = 16;

    // Effective configuration, already clamped.
    typedef struct packed {
        logic [2:0] log2_entries;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] init_counter;
        logic       global_hist;
        logic       global_table;
        logic [1:0] share_mode;
        logic       init_load;
    } t_cfg;

    // One classified item between front and back.
    typedef struct packed {
        logic              op;
        logic              taken;
        logic              flush;
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   target;
        logic [TAG_W-1:0]  tag;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CLEAR,
        ST_CALC
    } t_state;

endpackage

// File: design/btb_if.sv
// Request and response channel interfaces of the branch target buffer.
interface btb_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] branch_pc;
    logic [31:0] resolved_target;
    logic        resolved_taken;
    logic [31:0] earlier_prediction;

    modport source (output valid, operation, branch_pc, resolved_target,
                    resolved_taken, earlier_prediction, input ready);
    modport sink (input valid, operation, branch_pc, resolved_target,
                  resolved_taken, earlier_prediction, output ready);
endinterface

interface btb_rsp_if;
    logic        valid;
    logic        ready;
    logic        predict_taken;
    logic [31:0] predicted_target;
    logic [31:0] flush_total;
    logic [31:0] branch_total;

    modport source (output valid, predict_taken, predicted_target, flush_total,
                    branch_total, input ready);
    modport sink (input valid, predict_taken, predicted_target, flush_total,
                  branch_total, output ready);
endinterface

// File: design/btb_two_level_branch_predictor_top.sv
// Top level of the two-level branch target buffer. A predict or update
// request runs in the back end as a lookup with counter read, then a result
// and write-back, set by the read-modify-write of the counter tables. An
// update that allocates an entry in per-entry table mode first sweeps
// 2^history_bits counters of that entry, one per cycle. A two-entry queue
// decouples request acceptance from the back end, and a result register
// holds each result until it is taken. Registers have a plain write port;
// the user must write them only while the block is idle; it is not enforced.
module btb_two_level_branch_predictor_top #(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_HISTORY = 8,
    parameter int MAX_TAG     = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btb_req_if.sink    i_req,
    btb_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data
);
    localparam int LMAX = $clog2(MAX_ENTRIES + 1) - 1;

    logic [2:0] r_log2;
    logic [3:0] r_hbits;
    logic [4:0] r_tbits;
    logic [1:0] r_init, r_sm;
    logic       r_gh, r_gt, r_load;

    btb_pkg::t_cfg cfg;
    btb_pkg::t_job f_job, q_job;
    logic          push, pop, full, empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2  <= 3'd0;
            r_hbits <= 4'd1;
            r_tbits <= 5'd0;
            r_init  <= 2'd1;
            r_gh    <= 1'b0;
            r_gt    <= 1'b0;
            r_sm    <= 2'd0;
            r_load  <= 1'b1;
        end else begin
            r_load <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    btb_pkg::CFG_LOG2_ENTRIES: r_log2  <= i_cfg_data[2:0];
                    btb_pkg::CFG_HISTORY_BITS: r_hbits <= i_cfg_data[3:0];
                    btb_pkg::CFG_TAG_BITS:     r_tbits <= i_cfg_data[4:0];
                    btb_pkg::CFG_INIT_COUNTER: begin
                        r_init <= i_cfg_data[1:0];
                        r_load <= 1'b1;
                    end
                    btb_pkg::CFG_GLOBAL_HIST:  r_gh <= i_cfg_data[0];
                    btb_pkg::CFG_GLOBAL_TABLE: r_gt <= i_cfg_data[0];
                    btb_pkg::CFG_SHARE_MODE:   r_sm <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Clamped configuration.
    always_comb begin
        cfg.log2_entries = (int'(r_log2) > LMAX) ? 3'(LMAX) : r_log2;
        if (r_hbits == 4'd0)                  cfg.history_bits = 4'd1;
        else if (int'(r_hbits) > MAX_HISTORY) cfg.history_bits = 4'(MAX_HISTORY);
        else                                  cfg.history_bits = r_hbits;
        cfg.tag_bits     = (int'(r_tbits) > MAX_TAG) ? 5'(MAX_TAG) : r_tbits;
        cfg.init_counter = r_init;
        cfg.global_hist  = r_gh;
        cfg.global_table = r_gt;
        cfg.share_mode   = r_sm;
        cfg.init_load    = r_load;
    end

    btb_front u_front (
        .i_req  (i_req),
        .i_cfg  (cfg),
        .i_full (full),
        .o_push (push),
        .o_job  (f_job)
    );

    btb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (q_job)
    );

    btb_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );
endmodule

// File: design/btb_front.sv
// Front end: accepts request transfers, computes tag and misprediction flag.
module btb_front (
    btb_req_if.sink          i_req,
    input  btb_pkg::t_cfg    i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output btb_pkg::t_job    o_job
);
    logic [btb_pkg::TAG_W-1:0] word;
    logic [btb_pkg::TAG_W-1:0] tmask;
    logic [btb_pkg::PC_W-1:0]  fall;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Tag is the word address above the index, masked to the tag width.
    always_comb begin
        word  = i_req.branch_pc[31:2];
        tmask = ~({btb_pkg::TAG_W{1'b1}} << i_cfg.tag_bits);
        fall  = i_req.branch_pc + 32'd4;
        o_job.op     = i_req.operation;
        o_job.taken  = i_req.resolved_taken;
        o_job.pc     = i_req.branch_pc;
        o_job.target = i_req.resolved_target;
        o_job.tag    = (word >> i_cfg.log2_entries) & tmask;
        o_job.flush  = i_req.resolved_taken ? (i_req.resolved_target != i_req.earlier_prediction)
                                            : (fall != i_req.earlier_prediction);
    end
endmodule

// File: design/btb_fifo.sv
// Two-entry queue between front and back end.
module btb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btb_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output btb_pkg::t_job o_job
);
    btb_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

// File: design/btb_back.sv
// Back end: entry lookup, counter tables, allocation sweep and result register.
module btb_back #(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  btb_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  btb_pkg::t_job i_job,
    output logic          o_pop,
    btb_rsp_if.source     o_rsp
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int HW = MAX_HISTORY;
    localparam int SD = 1 << HW;

    btb_pkg::t_state r_st, n_st;
    btb_pkg::t_job   r_job;

    // Entry storage.
    logic                     r_ev   [MAX_ENTRIES];
    logic [btb_pkg::TAG_W-1:0] r_etag [MAX_ENTRIES];
    logic [31:0]              r_etgt [MAX_ENTRIES];
    logic [HW-1:0]            r_ehist[MAX_ENTRIES];
    logic [HW-1:0]            r_shist;

    // Counter memories.
    logic [1:0]    r_lmem [1 << (IW + HW)];
    logic [1:0]    r_smem [SD];
    logic [SD-1:0] r_sv;
    logic [1:0]    r_lrd, r_srd;

    logic [HW-1:0] r_pos, r_cnt;
    logic [31:0]   r_flush, r_branch;
    logic          r_ov;

    logic [IW-1:0] lmask, idx;
    logic [HW-1:0] hmask, xorv, hist, pos, newh;
    logic          hit, go, alloc;
    logic [1:0]    ctr, newctr;
    logic [29:0]   word;

    // Lookup of the entry, history and counter position.
    always_comb begin
        word  = r_job.pc[31:2];
        lmask = ~({IW{1'b1}} << i_cfg.log2_entries);
        hmask = ~({HW{1'b1}} << i_cfg.history_bits);
        idx   = word[IW-1:0] & lmask;
        hit   = r_ev[idx] && (r_etag[idx] == r_job.tag);
        case (i_cfg.share_mode)
            btb_pkg::SHARE_LOW:  xorv = word[HW-1:0];
            btb_pkg::SHARE_HIGH: xorv = HW'(word >> btb_pkg::SHARE_HIGH_LSB);
            default:             xorv = '0;
        endcase
        if (i_cfg.global_hist) hist = r_shist & hmask;
        else if (hit)          hist = r_ehist[idx] & hmask;
        else                   hist = '0;
        pos   = (hist ^ xorv) & hmask;
        alloc = (r_job.op == btb_pkg::OP_UPDATE) && !hit;
        newh  = ((hist << 1) | HW'(r_job.taken)) & hmask;
        ctr   = i_cfg.global_table ? (r_sv[r_pos] ? r_srd : i_cfg.init_counter) : r_lrd;
        if (r_job.taken) newctr = (ctr == 2'd3) ? ctr : ctr + 2'd1;
        else             newctr = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        go    = !r_ov || o_rsp.ready;
    end

    // Sequencer.
    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            btb_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_st  = btb_pkg::ST_LOOK;
                end
            end
            btb_pkg::ST_LOOK: begin
                n_st = (alloc && !i_cfg.global_table) ? btb_pkg::ST_CLEAR : btb_pkg::ST_CALC;
            end
            btb_pkg::ST_CLEAR: begin
                if (r_cnt == hmask) n_st = btb_pkg::ST_LOOK;
            end
            btb_pkg::ST_CALC: begin
                if (go) begin
                    o_pop = !i_empty;
                    n_st  = i_empty ? btb_pkg::ST_IDLE : btb_pkg::ST_LOOK;
                end
            end
            default: n_st = btb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= btb_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

    // Entry fields, histories, shared valid bits and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) r_ev[i] <= 1'b0;
            r_sv     <= '0;
            r_shist  <= '0;
            r_flush  <= '0;
            r_branch <= '0;
        end else begin
            if (i_cfg.init_load) r_sv <= '0;
            if (r_st == btb_pkg::ST_LOOK && alloc) begin
                r_ev[idx]    <= 1'b1;
                r_etag[idx]  <= r_job.tag;
                r_ehist[idx] <= '0;
            end
            if (r_st == btb_pkg::ST_CALC && go && r_job.op == btb_pkg::OP_UPDATE) begin
                r_etgt[idx] <= r_job.target;
                if (i_cfg.global_hist) r_shist <= newh;
                else                   r_ehist[idx] <= newh;
                if (i_cfg.global_table) r_sv[r_pos] <= 1'b1;
                r_branch <= r_branch + 32'd1;
                if (r_job.flush) r_flush <= r_flush + 32'd1;
            end
        end
    end

    // Position register and allocation sweep count.
    always_ff @(posedge i_clk) begin
        if (r_st == btb_pkg::ST_LOOK) begin
            r_pos <= pos;
            r_cnt <= '0;
        end else if (r_st == btb_pkg::ST_CLEAR) begin
            r_cnt <= r_cnt + HW'(1);
        end
    end

    // Per-entry counter memory.
    always_ff @(posedge i_clk) begin
        if (r_st == btb_pkg::ST_CLEAR)
            r_lmem[{idx, r_cnt}] <= i_cfg.init_counter;
        else if (r_st == btb_pkg::ST_CALC && go && r_job.op == btb_pkg::OP_UPDATE
                 && !i_cfg.global_table)
            r_lmem[{idx, r_pos}] <= newctr;
        r_lrd <= r_lmem[{idx, pos}];
    end

    // Shared counter memory.
    always_ff @(posedge i_clk) begin
        if (r_st == btb_pkg::ST_CALC && go && r_job.op == btb_pkg::OP_UPDATE
            && i_cfg.global_table)
            r_smem[r_pos] <= newctr;
        r_srd <= r_smem[pos];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == btb_pkg::ST_CALC && go) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == btb_pkg::ST_CALC && go) begin
            if (r_job.op == btb_pkg::OP_UPDATE) begin
                o_rsp.predict_taken    <= 1'b0;
                o_rsp.predicted_target <= '0;
                o_rsp.branch_total     <= r_branch + 32'd1;
                o_rsp.flush_total      <= r_flush + 32'(r_job.flush);
            end else begin
                o_rsp.predict_taken    <= hit && ctr[1];
                o_rsp.predicted_target <= (hit && ctr[1]) ? r_etgt[idx] : r_job.pc + 32'd4;
                o_rsp.branch_total     <= r_branch;
                o_rsp.flush_total      <= r_flush;
            end
        end
    end

    assign o_rsp.valid = r_ov;
endmodule
